[sv/led_current_dac_calibrator_unit_assert.svh]
// Assertion macros used by the LED current DAC calibrator RTL.
`ifndef LED_CURRENT_DAC_CALIBRATOR_UNIT_ASSERT_SVH
`define LED_CURRENT_DAC_CALIBRATOR_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define LDC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define LDC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/ldc_pkg.sv]
// Types, constants and helper functions of the LED current DAC calibrator.
package ldc_pkg;

  localparam int unsigned SamplesPerAverageDef = 6;

  localparam int unsigned AdcW     = 12;
  localparam int unsigned DacW     = 8;
  localparam int unsigned CmdW     = 9;
  localparam int unsigned TgtW     = 13;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 12;

  localparam logic [CfgIdxW-1:0] CfgCurrentCommand = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgInitialDac     = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgDeadband       = 2'd2;

  localparam logic [AdcW-1:0] DeadbandReset = 12'd10;
  localparam logic [DacW-1:0] DacMax        = 8'hFF;
  localparam int unsigned     AdcMax        = 4095;

  // Target is floor(command * 4096 / 330), done as a multiply by a rounded-up
  // reciprocal; the error stays far below one part in 330 for 9-bit commands.
  localparam int unsigned TgtShift    = 24;
  localparam int unsigned TgtRecipW   = 28;
  localparam logic [TgtRecipW-1:0] TgtRecip =
    TgtRecipW'(((64'd1 << (TgtShift + 12)) + 64'd329) / 64'd330);

  typedef enum logic {
    KIND_START  = 1'b0,
    KIND_SAMPLE = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    STAT_STEP      = 2'd0,
    STAT_BAND      = 2'd1,
    STAT_OVERSHOOT = 2'd2,
    STAT_LIMIT     = 2'd3
  } status_e;

  typedef struct packed {
    kind_e           kind;
    logic [AdcW-1:0] adc_sample;
  } req_t;

  typedef struct packed {
    logic [DacW-1:0] dac_code;
    status_e         status;
    logic [AdcW-1:0] average_reading;
    logic [AdcW-1:0] final_sample;
  } res_t;

  function automatic logic [TgtW-1:0] target_from_command(input logic [CmdW-1:0] cmd);
    logic [CmdW+TgtRecipW-1:0] prod;
    prod = (CmdW+TgtRecipW)'(cmd) * (CmdW+TgtRecipW)'(TgtRecip);
    return prod[TgtShift +: TgtW];
  endfunction

endpackage

[sv/led_current_dac_calibrator_unit.sv]
// Top level of the LED current DAC calibrator.
// Requests arrive on in_valid_i/in_ready_o with in_data_i: a start request loads the
// DAC code from the initial_dac register and computes the target reading from
// current_command; sample requests carry one 12-bit shunt ADC reading each.
// Every SamplesPerAverage samples are averaged and one result is sent on
// out_valid_o/out_ready_i: the DAC code to drive, a status, the average and the
// last sample. A zero target ends on the first sample.
// The user must write the registers through cfg_we_i, cfg_idx_i and cfg_data_i
// only while idle; the block itself does not enforce it. An accepted request
// passes one input register and then one result register before its result is
// shown. One request is taken every cycle unless a result waits on a full result
// register; decision logic is one stage around the averaging-division multiply.
// A full result register does not stop input: requests that make no result
// keep flowing, and a request that makes one waits only while the result
// register is full and out_ready_i is low.
// After reset the block is idle, registers hold their reset values and sample
// requests are dropped until a start request arrives.
`include "led_current_dac_calibrator_unit_assert.svh"

module led_current_dac_calibrator_unit
  import ldc_pkg::*;
#(
  parameter int unsigned SamplesPerAverage = SamplesPerAverageDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  req_t                in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output res_t                out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned SumMax    = SamplesPerAverage * AdcMax;
  localparam int unsigned SumW      = $clog2(SumMax + 1);
  localparam int unsigned CntW      = (SamplesPerAverage > 1) ? $clog2(SamplesPerAverage) : 1;
  localparam int unsigned AvgShift  = 20;
  localparam int unsigned AvgRecipW = AvgShift + 1;
  localparam logic [AvgRecipW-1:0] AvgRecip =
    AvgRecipW'(((64'd1 << AvgShift) + 64'(SamplesPerAverage) - 64'd1) /
               64'(SamplesPerAverage));
  localparam logic [CntW-1:0] CntLast = CntW'(SamplesPerAverage - 1);
  localparam logic [SumW-1:0] SumBound = SumW'((SamplesPerAverage - 1) * AdcMax);

  logic [CmdW-1:0] cmd_q;
  logic [DacW-1:0] init_q;
  logic [AdcW-1:0] deadband_q;

  logic            stg_vld_q;
  req_t            stg_q;
  logic            out_vld_q;
  res_t            out_q;

  logic            run_q, run_d;
  logic [SumW-1:0] sum_q, sum_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DacW-1:0] dac_q, dac_d;
  logic [TgtW-1:0] tgt_q, tgt_d;
  logic [AdcW-1:0] prev_q, prev_d;
  logic            up_q, up_d;
  logic            moved_q, moved_d;

  logic                     produce;
  logic                     adv;
  res_t                     res;
  logic [SumW-1:0]          new_sum;
  logic [SumW+AvgRecipW-1:0] avg_prod;
  logic [AdcW-1:0]          avg;
  logic signed [13:0]       t_s, a_s, p_s, db_s;
  logic signed [13:0]       d_at, d_ta, d_tp, d_pa;

  assign new_sum  = sum_q + SumW'(stg_q.adc_sample);
  assign avg_prod = (SumW+AvgRecipW)'(new_sum) * (SumW+AvgRecipW)'(AvgRecip);
  assign avg      = avg_prod[AvgShift +: AdcW];

  assign t_s  = $signed({1'b0, tgt_q});
  assign a_s  = $signed({2'b00, avg});
  assign p_s  = $signed({2'b00, prev_q});
  assign db_s = $signed({2'b00, deadband_q});
  assign d_at = a_s - t_s;
  assign d_ta = t_s - a_s;
  assign d_tp = t_s - p_s;
  assign d_pa = p_s - a_s;

  always_comb begin
    run_d   = run_q;
    sum_d   = sum_q;
    cnt_d   = cnt_q;
    dac_d   = dac_q;
    tgt_d   = tgt_q;
    prev_d  = prev_q;
    up_d    = up_q;
    moved_d = moved_q;
    produce = 1'b0;
    res.status          = STAT_STEP;
    res.average_reading = avg;
    res.final_sample    = stg_q.adc_sample;
    if (stg_vld_q) begin
      if (stg_q.kind == KIND_START) begin
        dac_d   = init_q;
        tgt_d   = target_from_command(cmd_q);
        sum_d   = '0;
        cnt_d   = '0;
        prev_d  = '0;
        up_d    = 1'b0;
        moved_d = 1'b0;
        run_d   = 1'b1;
      end else if (run_q) begin
        if (tgt_q == '0) begin
          run_d               = 1'b0;
          produce             = 1'b1;
          res.status          = STAT_BAND;
          res.average_reading = stg_q.adc_sample;
        end else if (cnt_q != CntLast) begin
          sum_d = new_sum;
          cnt_d = cnt_q + 1'b1;
        end else begin
          sum_d   = '0;
          cnt_d   = '0;
          produce = 1'b1;
          if (d_at > 14'sd0) begin
            if (d_at <= db_s) begin
              run_d      = 1'b0;
              res.status = STAT_BAND;
            end else if (moved_q && up_q && (d_tp < d_at)) begin
              run_d      = 1'b0;
              res.status = STAT_OVERSHOOT;
            end else if (dac_q == '0) begin
              run_d      = 1'b0;
              res.status = STAT_LIMIT;
            end else begin
              up_d    = 1'b0;
              prev_d  = avg;
              moved_d = 1'b1;
              dac_d   = dac_q - 1'b1;
            end
          end else begin
            if (d_ta <= db_s) begin
              run_d      = 1'b0;
              res.status = STAT_BAND;
            end else if (moved_q && !up_q && (d_ta < d_pa)) begin
              run_d      = 1'b0;
              res.status = STAT_OVERSHOOT;
            end else if (dac_q == DacMax) begin
              run_d      = 1'b0;
              res.status = STAT_LIMIT;
            end else begin
              up_d    = 1'b1;
              prev_d  = avg;
              moved_d = 1'b1;
              dac_d   = dac_q + 1'b1;
            end
          end
        end
      end
    end
    res.dac_code = dac_d;
  end

  assign adv        = stg_vld_q && (!out_vld_q || out_ready_i || !produce);
  assign in_ready_o = !stg_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q      <= '0;
      init_q     <= '0;
      deadband_q <= DeadbandReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgCurrentCommand: cmd_q      <= cfg_data_i[CmdW-1:0];
        CfgInitialDac:     init_q     <= cfg_data_i[DacW-1:0];
        CfgDeadband:       deadband_q <= cfg_data_i[AdcW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      stg_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      stg_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= 1'b0;
      sum_q   <= '0;
      cnt_q   <= '0;
      dac_q   <= '0;
      tgt_q   <= '0;
      prev_q  <= '0;
      up_q    <= 1'b0;
      moved_q <= 1'b0;
    end else if (adv) begin
      run_q   <= run_d;
      sum_q   <= sum_d;
      cnt_q   <= cnt_d;
      dac_q   <= dac_d;
      tgt_q   <= tgt_d;
      prev_q  <= prev_d;
      up_q    <= up_d;
      moved_q <= moved_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv && produce) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && produce) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  `LDC_ASSERT_NXT(a_start_clears, adv && (stg_q.kind == KIND_START),
                  run_q && (cnt_q == '0) && (sum_q == '0) && !moved_q,
                  "start request did not reset the calibration state")
  `LDC_ASSERT_NXT(a_stop_idles, adv && produce && (res.status != STAT_STEP), !run_q,
                  "calibration still running after a final result")
  `LDC_ASSERT_IMP(a_prev_clear, !moved_q, (prev_q == '0) && !up_q,
                  "direction history set before any step")
  `LDC_ASSERT_IMP(a_sum_bound, 1'b1, (sum_q <= SumBound) && (cnt_q <= CntLast),
                  "sample accumulator exceeded one averaging window")

endmodule
